// ===== rtl/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants of the homogeneous point transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 32;
  localparam int SUM_W     = 64;

  // Queue between front and back
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  // One quotient bit per divider stage
  localparam int DIV_STEPS = 32;

  // Transformed point with its w and the divide decision
  typedef struct packed {
    logic signed [SUM_W-1:0] ax;
    logic signed [SUM_W-1:0] ay;
    logic signed [SUM_W-1:0] az;
    logic signed [SUM_W-1:0] w;
    logic                    divide;
  } hpt_item_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } hpt_qstat_t;

  // Divider stage contents for the three lanes: partial remainder,
  // remaining numerator bits shifted out as quotient bits shift in.
  typedef struct packed {
    logic [2:0][SUM_W-1:0]   rem;
    logic [2:0][COORD_W-1:0] nq;
    logic [SUM_W-1:0]        den;
    logic [2:0]              neg;
    logic [2:0]              big;
    logic                    divided;
  } hpt_div_t;

endpackage

`default_nettype wire

// ===== rtl/homogeneous_point_transform_unit.sv =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform_unit
// Q16.16 point times 4x4 column-major matrix, divide by w unless w is 0 or 1.0, clamp to 32 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive point_x/y/z and raise push; the point is taken
//   on a clock edge with push high and full low. Result queue side: while
//   empty is low the oldest result sits on result_*, was_divided and
//   saturated; raise pop to take it.
//   Matrix: eight 64-bit registers written through cfg_write, cfg_index and
//   cfg_data, one per cycle; the user must write them only while no point
//   is in flight, as the block does not enforce this. Reset loads the
//   identity matrix and empties every stage. Throughput: one point per
//   cycle while results are popped. Stages: the multiply, 2 sum stages,
//   the queue, 1 divider setup stage, 32 quotient stages and 1 output
//   register.
//   A four-entry queue parts the multiply front from the divider. When pop
//   is held low the divider pipeline holds, then the queue fills, then the
//   front holds and full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform_unit import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [REG_W-1:0]            cfg_data,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic signed [COORD_W-1:0]   point_x,
  input  wire logic signed [COORD_W-1:0]   point_y,
  input  wire logic signed [COORD_W-1:0]   point_z,
  input  wire logic                        pop,
  output logic                             empty,
  output logic signed [COORD_W-1:0]        result_x,
  output logic signed [COORD_W-1:0]        result_y,
  output logic signed [COORD_W-1:0]        result_z,
  output logic                             was_divided,
  output logic                             saturated
);

  hpt_item_t  f_item;
  hpt_item_t  b_item;
  hpt_qstat_t qstat;
  logic       q_push;
  logic       q_pop;

  hpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .q_item    (f_item),
    .q_push    (q_push),
    .q_full    (qstat.full)
  );

  hpt_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_push),
    .din  (f_item),
    .rd   (q_pop),
    .dout (b_item),
    .stat (qstat)
  );

  hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_item      (b_item),
    .q_empty     (qstat.empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .result_x    (result_x),
    .result_y    (result_y),
    .result_z    (result_z),
    .was_divided (was_divided),
    .saturated   (saturated)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_q_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty)
    else $error("divider pulled from an empty queue");

  a_q_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !qstat.full)
    else $error("front pushed into a full queue");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result present right after reset");

endmodule

`default_nettype wire

// ===== rtl/hpt_front.sv =====
// ----------------------------------------------------------------------------
// hpt_front
// Matrix registers, 4x3 multiply and row sums; classifies w for the divide.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_front import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [REG_W-1:0]            cfg_data,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic signed [COORD_W-1:0]   point_x,
  input  wire logic signed [COORD_W-1:0]   point_y,
  input  wire logic signed [COORD_W-1:0]   point_z,
  output hpt_item_t                        q_item,
  output logic                             q_push,
  input  wire logic                        q_full
);

  localparam logic [COORD_W-1:0] ONE_FIX = COORD_W'(1) << FRAC_BITS;

  logic [REG_W-1:0] cfg_regs [NUM_REGS];
  logic signed [COORD_W-1:0] ent [4][4];   // [column][row]
  logic signed [COORD_W-1:0] pt [3];

  logic signed [SUM_W-1:0]   prod [4][3];
  logic signed [COORD_W-1:0] tr [4];
  logic signed [SUM_W-1:0]   sa [4];
  logic signed [SUM_W-1:0]   sb [4];
  logic signed [SUM_W-1:0]   acc [4];
  logic v1, v2, v3;
  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs[0] <= {{COORD_W{1'b0}}, ONE_FIX};
      cfg_regs[1] <= '0;
      cfg_regs[2] <= {ONE_FIX, {COORD_W{1'b0}}};
      cfg_regs[3] <= '0;
      cfg_regs[4] <= '0;
      cfg_regs[5] <= {{COORD_W{1'b0}}, ONE_FIX};
      cfg_regs[6] <= '0;
      cfg_regs[7] <= {ONE_FIX, {COORD_W{1'b0}}};
    end else if (cfg_write) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    for (genvar r = 0; r < 4; r++) begin : g_row
      if (r % 2 == 1) begin : g_hi
        assign ent[c][r] = cfg_regs[2*c + r/2][REG_W-1:COORD_W];
      end else begin : g_lo
        assign ent[c][r] = cfg_regs[2*c + r/2][COORD_W-1:0];
      end
    end
  end

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  // Hold the whole front while the last stage cannot drain
  assign en     = !v3 || !q_full;
  assign full   = !en;
  assign q_push = v3 && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) prod[r][c] <= ent[c][r] * pt[c];
        tr[r]  <= ent[3][r];
        // arithmetic shift rounds toward minus infinity
        sa[r]  <= (prod[r][0] >>> FRAC_BITS) + (prod[r][1] >>> FRAC_BITS);
        sb[r]  <= (prod[r][2] >>> FRAC_BITS) + SUM_W'(tr[r]);
        acc[r] <= sa[r] + sb[r];
      end
    end
  end

  always_comb begin
    q_item.ax     = acc[0];
    q_item.ay     = acc[1];
    q_item.az     = acc[2];
    q_item.w      = acc[3];
    q_item.divide = (acc[3] != '0) && (acc[3] != SUM_W'(ONE_FIX));
  end

endmodule

`default_nettype wire

// ===== rtl/hpt_queue.sv =====
// ----------------------------------------------------------------------------
// hpt_queue
// Short queue that decouples the multiply front from the divide back.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_queue import hpt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr,
  input  hpt_item_t      din,
  input  wire logic      rd,
  output hpt_item_t      dout,
  output hpt_qstat_t     stat
);

  hpt_item_t mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (rd) rd_ptr <= rd_ptr + Q_PTR_W'(1);
      case ({wr, rd})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= din;
  end

  assign dout       = mem[rd_ptr];
  assign stat.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.count = count;

endmodule

`default_nettype wire

// ===== rtl/hpt_back.sv =====
// ----------------------------------------------------------------------------
// hpt_back
// Perspective divide: one quotient bit per stage on three lanes, then clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_back import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  hpt_item_t                      q_item,
  input  wire logic                      q_empty,
  output logic                           q_pop,
  input  wire logic                      pop,
  output logic                           empty,
  output logic signed [COORD_W-1:0]      result_x,
  output logic signed [COORD_W-1:0]      result_y,
  output logic signed [COORD_W-1:0]      result_z,
  output logic                           was_divided,
  output logic                           saturated
);

  localparam logic [COORD_W-1:0] MIN_MAG = COORD_W'(1) << (COORD_W - 1);

  hpt_div_t stg [DIV_STEPS+1];
  logic     vld [DIV_STEPS+1];
  hpt_div_t first;
  logic     vo;
  logic     en;

  logic [COORD_W-1:0] res [3];
  logic [2:0]         sat;

  function automatic hpt_div_t div_step(input hpt_div_t s);
    hpt_div_t   o;
    logic [SUM_W:0] t;
    logic       ge;
    o = s;
    for (int l = 0; l < 3; l++) begin
      t  = {s.rem[l], s.nq[l][COORD_W-1]};
      ge = (t >= {1'b0, s.den});
      if (ge) t = t - {1'b0, s.den};
      o.rem[l] = t[SUM_W-1:0];
      o.nq[l]  = {s.nq[l][COORD_W-2:0], ge};
    end
    return o;
  endfunction

  // Advance everything when the output slot is free or being taken
  assign en    = !vo || pop;
  assign q_pop = en && !q_empty;
  assign empty = !vo;

  always_comb begin
    logic signed [SUM_W-1:0] a [3];
    logic [SUM_W-1:0] m;
    logic [SUM_W-1:0] n;
    logic [SUM_W-1:0] dmag;
    a[0] = q_item.ax;
    a[1] = q_item.ay;
    a[2] = q_item.az;
    dmag = q_item.w[SUM_W-1] ? SUM_W'(-q_item.w) : SUM_W'(q_item.w);
    first.divided = q_item.divide;
    first.den     = q_item.divide ? dmag : SUM_W'(1);
    for (int l = 0; l < 3; l++) begin
      m = a[l][SUM_W-1] ? SUM_W'(-a[l]) : SUM_W'(a[l]);
      n = m << FRAC_BITS;
      if (q_item.divide) begin
        first.neg[l] = a[l][SUM_W-1] ^ q_item.w[SUM_W-1];
        // quotient of 2^32 or more is clamped anyway
        first.big[l] = ({{COORD_W{1'b0}}, n[SUM_W-1:COORD_W]} >= dmag);
        first.rem[l] = {{COORD_W{1'b0}}, n[SUM_W-1:COORD_W]};
        first.nq[l]  = n[COORD_W-1:0];
      end else begin
        // divide by one passes the low word through unchanged
        first.neg[l] = a[l][SUM_W-1];
        first.big[l] = (m[SUM_W-1:COORD_W] != '0);
        first.rem[l] = '0;
        first.nq[l]  = m[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) vld[k] <= 1'b0;
      vo <= 1'b0;
    end else if (en) begin
      vld[0] <= q_pop;
      for (int k = 0; k < DIV_STEPS; k++) vld[k+1] <= vld[k];
      vo <= vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) stg[0] <= first;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) stg[k+1] <= div_step(stg[k]);
    end
  end

  always_comb begin
    logic [COORD_W-1:0] q;
    for (int l = 0; l < 3; l++) begin
      q = stg[DIV_STEPS].nq[l];
      if (stg[DIV_STEPS].neg[l]) begin
        sat[l] = stg[DIV_STEPS].big[l] || (q > MIN_MAG);
        res[l] = sat[l] ? MIN_MAG : (~q + COORD_W'(1));
      end else begin
        sat[l] = stg[DIV_STEPS].big[l] || q[COORD_W-1];
        res[l] = sat[l] ? (MIN_MAG - COORD_W'(1)) : q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_x    <= res[0];
      result_y    <= res[1];
      result_z    <= res[2];
      was_divided <= stg[DIV_STEPS].divided;
      saturated   <= |sat;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the homogeneous point transform unit: points are
// pushed in bursts under a stalling result side, each accepted point is run
// through a local fixed-point transform with the current matrix, and every
// popped result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpt_pkg::*;

  localparam int FRAC       = 16;
  localparam int DRAIN      = 50;
  localparam int IDLE_LIMIT = 3000;
  localparam int MAX_SHOWN  = 40;
  localparam logic [31:0] FIX_ONE = 32'h0001_0000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      divided;
    logic                      sat;
  } point_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic pop = 1'b0;
  logic empty;
  logic signed [COORD_W-1:0] result_x;
  logic signed [COORD_W-1:0] result_y;
  logic signed [COORD_W-1:0] result_z;
  logic was_divided;
  logic saturated;

  logic [REG_W-1:0] matrix [NUM_REGS];
  point_result_t pending_points [$];
  int errors = 0;
  int idle_count = 0;
  int burst_left = 0;

  homogeneous_point_transform_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .pop(pop), .empty(empty),
    .result_x(result_x), .result_y(result_y), .result_z(result_z),
    .was_divided(was_divided), .saturated(saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint mat_entry(int col, int row);
    logic [REG_W-1:0] r;
    r = matrix[col * 2 + row / 2];
    return (row % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
  endfunction

  // Products floor-shifted (arithmetic shift), then summed with the translation.
  function automatic longint row_sum(int row, longint px, longint py, longint pz);
    return mat_entry(3, row) + ((mat_entry(0, row) * px) >>> FRAC)
         + ((mat_entry(1, row) * py) >>> FRAC) + ((mat_entry(2, row) * pz) >>> FRAC);
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Returns {clamped, value}.
  function automatic logic [32:0] clamp_coord(logic neg, logic [63:0] m);
    if (neg) begin
      if (m > 64'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'(-m)};
    end
    if (m > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, m[31:0]};
  endfunction

  function automatic point_result_t predict_point(logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic signed [31:0] pz);
    point_result_t res;
    longint acc [3];
    longint w;
    logic divide;
    logic neg;
    logic [63:0] m;
    logic [32:0] c;
    logic [31:0] coord [3];
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) acc[i] = row_sum(i, px, py, pz);
    w = row_sum(3, px, py, pz);
    divide = (w != 0) && (w != longint'(FIX_ONE));
    for (int i = 0; i < 3; i++) begin
      neg = acc[i] < 0;
      m = magnitude(acc[i]);
      if (divide) begin
        m = (m << FRAC) / magnitude(w);
        neg = neg != (w < 0);
      end
      c = clamp_coord(neg, m);
      coord[i] = c[31:0];
      res.sat = res.sat | c[32];
    end
    res.x = coord[0];
    res.y = coord[1];
    res.z = coord[2];
    res.divided = divide;
    return res;
  endfunction

  // ------------------------------------------------- request and result sides
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) matrix[i] = '0;
      matrix[0] = 64'(FIX_ONE);
      matrix[2] = {FIX_ONE, 32'h0};
      matrix[5] = 64'(FIX_ONE);
      matrix[7] = {FIX_ONE, 32'h0};
    end else begin
      if (cfg_write) matrix[cfg_index] = cfg_data;
      if (push && !full) pending_points.push_back(predict_point(point_x, point_y, point_z));
    end
  end

  always @(posedge clk) begin
    point_result_t exp_r;
    if (!rst && pop && !empty) begin
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: x=%h y=%h z=%h", $realtime,
                 result_x, result_y, result_z);
      end else begin
        exp_r = pending_points.pop_front();
        if (exp_r.x !== result_x || exp_r.y !== result_y || exp_r.z !== result_z ||
            exp_r.divided !== was_divided || exp_r.sat !== saturated) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: mismatch expected x=%h y=%h z=%h div=%b sat=%b, actual x=%h y=%h z=%h div=%b sat=%b",
                     $realtime, exp_r.x, exp_r.y, exp_r.z, exp_r.divided, exp_r.sat,
                     result_x, result_y, result_z, was_divided, saturated);
        end
      end
    end
  end

  // Receiver stall pattern: random modes in which pop is always high, random, rarely high or held low.
  int pop_mode = 0;
  int pop_left = 0;
  always @(posedge clk) begin
    if (pop_left == 0) begin
      pop_mode = $urandom_range(0, 3);
      pop_left = $urandom_range(32, 200);
    end else begin
      pop_left--;
    end
    case (pop_mode)
      0: pop <= 1'b1;
      1: pop <= $urandom_range(0, 1);
      2: pop <= ($urandom_range(0, 4) == 0);
      default: pop <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst || cfg_write) idle_count = 0;
    else idle_count++;
    if (idle_count >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------- driver
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    do @(posedge clk); while (full);
  endtask

  // Hold off until every request has come back, then let the pipe empty.
  task automatic wait_for_drain();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic load_matrix(logic [REG_W-1:0] regs [NUM_REGS]);
    wait_for_drain();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= regs[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
      2: return 32'h0;
      3: return FIX_ONE;
      4: return -FIX_ONE;
      default: return 32'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
  endfunction

  // -------------------------------------------------------------------- tests
  task automatic test_identity_extremes();
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    send_point(32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
    send_point(FIX_ONE, -FIX_ONE, 32'h1234_5678);
  endtask

  task automatic test_w_zero();
    logic [REG_W-1:0] r [NUM_REGS];
    r = '{64'(FIX_ONE), 64'h0, {FIX_ONE, 32'h0}, 64'h0,
          64'h0, 64'(FIX_ONE), 64'h0, 64'h0};
    load_matrix(r);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000);
    send_point(32'h0, 32'h0, 32'h0);
  endtask

  // w = -z, z' = z - 2.0: covers w of one, zero, negative and tiny w.
  task automatic test_perspective();
    logic [REG_W-1:0] r [NUM_REGS];
    r = '{64'(FIX_ONE), 64'h0, {FIX_ONE, 32'h0}, 64'h0,
          64'h0, {-FIX_ONE, FIX_ONE}, 64'h0, {32'h0, -(FIX_ONE * 2)}};
    load_matrix(r);
    send_point(32'h0003_0000, 32'hFFFE_0000, -FIX_ONE);
    send_point(32'h0003_0000, 32'h0005_0000, 32'h0);
    send_point(32'h0003_0000, 32'hFFFE_0000, -(FIX_ONE * 2));
    send_point(32'h0001_8000, 32'h0002_4000, 32'h0000_8000);
    send_point(32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_point(32'h8000_0000, 32'h0100_0000, 32'hFFFF_FFFF);
    send_point(32'h0100_0000, 32'h8000_0000, 32'h0000_0001);
    send_point(32'h0000_0007, 32'hFFFF_FFF9, 32'hFFFD_0000);
  endtask

  task automatic test_extreme_matrix();
    logic [REG_W-1:0] r [NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++) r[i] = 64'h7FFF_FFFF_8000_0000;
    load_matrix(r);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    for (int i = 0; i < NUM_REGS; i++) r[i] = {64{1'b1}};
    load_matrix(r);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    for (int i = 0; i < NUM_REGS; i++) r[i] = 64'h0;
    load_matrix(r);
    send_point(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_streams();
    logic [REG_W-1:0] r [NUM_REGS];
    for (int phase = 0; phase < 8; phase++) begin
      for (int i = 0; i < NUM_REGS; i++) r[i] = {rand_entry(), rand_entry()};
      // Keep an affine w row in some phases so the pass-through path stays busy.
      if (phase % 3 == 0) begin
        r[1][63:32] = 32'h0;
        r[3][63:32] = 32'h0;
        r[5][63:32] = 32'h0;
        r[7][63:32] = FIX_ONE;
      end
      load_matrix(r);
      for (int n = 0; n < 135; n++) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
        if (phase == 4 && n == 60) wait_for_drain();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity_extremes();
    test_w_zero();
    test_perspective();
    test_extreme_matrix();
    test_random_streams();
    wait_for_drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
